// ----- hdl/lph_pkg.sv -----
// Shared types and constants for the linear probe hash table.
// No dependencies; used by every module of the block.
package lph_pkg;

    localparam int TABLE_SIZE_DEF = 16;

    localparam int KEY_W       = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 4;
    localparam int OUT_TDATA_W = 8;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED    = 2'd3;

    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_USED    = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_MOD,
        CTL_PROBE,
        CTL_DONE
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic probe;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic mod_last;
        logic probe_done;
        logic out_busy;
    } dp_sts_t;

endpackage

// ----- hdl/lph_ctrl.sv -----
// Controller state machine: sequences home-slot reduction, probing and result hand-off.
// Depends on lph_pkg.
module lph_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output lph_pkg::dp_cmd_t  cmd,
    input  lph_pkg::dp_sts_t  sts
);

    lph_pkg::ctl_state_t state_reg;
    lph_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lph_pkg::CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lph_pkg::CTL_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = lph_pkg::CTL_MOD;
                end
            end
            lph_pkg::CTL_MOD:
            begin
                if (sts.mod_last)
                begin
                    state_next = lph_pkg::CTL_PROBE;
                end
            end
            lph_pkg::CTL_PROBE:
            begin
                if (sts.probe_done)
                begin
                    state_next = lph_pkg::CTL_DONE;
                end
            end
            lph_pkg::CTL_DONE:
            begin
                if (!sts.out_busy)
                begin
                    state_next = lph_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = lph_pkg::CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            lph_pkg::CTL_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            lph_pkg::CTL_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            lph_pkg::CTL_PROBE:
            begin
                cmd.probe = 1'b1;
            end
            lph_pkg::CTL_DONE:
            begin
                cmd.out_load = !sts.out_busy;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/lph_dp.sv -----
// Datapath: byte-wise key reduction, slot memories, probe pipeline and output register.
// Depends on lph_pkg; driven by lph_ctrl.
module lph_dp #(
    parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lph_pkg::KEY_W-1:0]           in_key,
    input  logic [lph_pkg::KIND_W-1:0]          in_kind,
    input  lph_pkg::dp_cmd_t                    cmd,
    output lph_pkg::dp_sts_t                    sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lph_pkg::STATUS_W-1:0]        m_status,
    output logic [lph_pkg::SLOT_W-1:0]          m_slot
);

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int KEY_BYTES = lph_pkg::KEY_W / 8;
    localparam int CNT_W = $clog2(KEY_BYTES);
    localparam logic [IDX_W:0]   TS_V      = (IDX_W+1)'(TABLE_SIZE);
    localparam logic [IDX_W:0]   TS_M1     = (IDX_W+1)'(TABLE_SIZE - 1);
    localparam logic [IDX_W-1:0] LAST_POS  = IDX_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] BYTE_LAST = CNT_W'(KEY_BYTES - 1);

    logic [lph_pkg::KEY_W-1:0]    key_reg;
    logic [lph_pkg::KEY_W-1:0]    key_sh_reg;
    logic [lph_pkg::KIND_W-1:0]   kind_reg;
    logic [CNT_W-1:0]             byte_cnt_reg;
    logic [IDX_W-1:0]             rem_reg;
    logic [IDX_W:0]               rem_sum;
    logic [IDX_W-1:0]             rem_next;
    logic [IDX_W-1:0]             byte_mod_tbl [256];
    logic [IDX_W-1:0]             shl_mod_tbl [1 << IDX_W];

    logic [IDX_W-1:0]             pos_reg;
    logic [IDX_W:0]               issue_cnt_reg;
    logic                         issue;
    logic                         pend_valid_reg;
    logic                         pend_last_reg;
    logic [IDX_W-1:0]             pend_pos_reg;

    logic [lph_pkg::KEY_W-1:0]    key_mem [TABLE_SIZE];
    logic [1:0]                   state_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]        vld_reg;

    logic [lph_pkg::KEY_W-1:0]    rd_key_reg;
    logic [1:0]                   rd_state_reg;
    logic                         rd_vld_reg;
    logic [1:0]                   eff_state;

    logic                         is_ins;
    logic                         is_del;
    logic                         is_find;
    logic                         hit;
    logic                         finish;

    logic [lph_pkg::STATUS_W-1:0] res_status_reg;
    logic [lph_pkg::SLOT_W-1:0]   res_slot_reg;
    logic [lph_pkg::SLOT_W-1:0]   slot_low;
    logic                         m_valid_reg;
    logic [lph_pkg::STATUS_W-1:0] m_status_reg;
    logic [lph_pkg::SLOT_W-1:0]   m_slot_reg;

    // constant tables: byte mod TABLE_SIZE and (r * 256) mod TABLE_SIZE
    generate
        for (genvar g = 0; g < 256; g++)
        begin : g_byte_mod
            assign byte_mod_tbl[g] = IDX_W'(g % TABLE_SIZE);
        end
        for (genvar g = 0; g < (1 << IDX_W); g++)
        begin : g_shl_mod
            assign shl_mod_tbl[g] = IDX_W'((g * 256) % TABLE_SIZE);
        end
    endgenerate

    // key mod TABLE_SIZE, one key byte per cycle, MSB first
    assign rem_sum  = {1'b0, shl_mod_tbl[rem_reg]} +
                      {1'b0, byte_mod_tbl[key_sh_reg[lph_pkg::KEY_W-1 -: 8]]};
    assign rem_next = (rem_sum >= TS_V) ? IDX_W'(rem_sum - TS_V) : IDX_W'(rem_sum);

    assign is_ins  = (kind_reg == lph_pkg::KIND_INSERT);
    assign is_del  = (kind_reg == lph_pkg::KIND_DELETE);
    assign is_find = (kind_reg == lph_pkg::KIND_SEARCH) || is_del;

    assign issue     = cmd.probe && (issue_cnt_reg != TS_V);
    assign eff_state = rd_vld_reg ? rd_state_reg : lph_pkg::SLOT_EMPTY;
    assign hit       = (is_ins && (eff_state == lph_pkg::SLOT_EMPTY)) ||
                       (is_find && (eff_state == lph_pkg::SLOT_USED) && (rd_key_reg == key_reg));
    assign finish    = cmd.probe && pend_valid_reg && (hit || pend_last_reg);

    generate
        if (IDX_W >= lph_pkg::SLOT_W)
        begin : g_slot_trunc
            assign slot_low = pend_pos_reg[lph_pkg::SLOT_W-1:0];
        end
        else
        begin : g_slot_ext
            assign slot_low = {{(lph_pkg::SLOT_W-IDX_W){1'b0}}, pend_pos_reg};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg    <= in_key;
            key_sh_reg <= in_key;
            kind_reg   <= in_kind;
        end
        else if (cmd.mod_step)
        begin
            key_sh_reg <= {key_sh_reg[lph_pkg::KEY_W-9:0], 8'h00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg   <= '0;
            rem_reg        <= '0;
            pos_reg        <= '0;
            issue_cnt_reg  <= '0;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            byte_cnt_reg   <= '0;
            rem_reg        <= '0;
            issue_cnt_reg  <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.mod_step)
        begin
            byte_cnt_reg <= byte_cnt_reg + 1'b1;
            rem_reg      <= rem_next;
            if (byte_cnt_reg == BYTE_LAST)
            begin
                pos_reg <= rem_next;
            end
        end
        else if (cmd.probe)
        begin
            pend_valid_reg <= issue && !finish;
            pend_last_reg  <= (issue_cnt_reg == TS_M1);
            if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
                pos_reg       <= (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_pos_reg <= pos_reg;
            rd_key_reg   <= key_mem[pos_reg];
            rd_state_reg <= state_mem[pos_reg];
            rd_vld_reg   <= vld_reg[pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish && hit && is_ins)
        begin
            key_mem[pend_pos_reg] <= key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish && hit && is_ins)
        begin
            state_mem[pend_pos_reg] <= lph_pkg::SLOT_USED;
        end
        else if (finish && hit && is_del)
        begin
            state_mem[pend_pos_reg] <= lph_pkg::SLOT_DELETED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (finish && hit && is_ins)
        begin
            vld_reg[pend_pos_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (hit)
            begin
                res_status_reg <= lph_pkg::STATUS_DONE;
                res_slot_reg   <= slot_low;
            end
            else
            begin
                res_status_reg <= is_ins ? lph_pkg::STATUS_FULL : lph_pkg::STATUS_NOT_FOUND;
                res_slot_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
        end
    end

    assign sts.mod_last   = cmd.mod_step && (byte_cnt_reg == BYTE_LAST);
    assign sts.probe_done = finish;
    assign sts.out_busy   = m_valid_reg && !m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;

endmodule

// ----- hdl/linear_probe_hash_table_top.sv -----
// Top level of the linear probe hash table: controller plus datapath.
// Depends on lph_pkg, lph_ctrl and lph_dp.
//
// Open-addressed hash table of TABLE_SIZE slots with linear probing. Each input item
// is an insert, search or delete of a 32-bit key and gives one result item. One item
// is in work at a time: a new item is accepted only once the last result is in the
// output register. The key is reduced to its home slot one byte per cycle, then one
// slot memory read per cycle walks the probe over 1 to TABLE_SIZE slots. A result
// waits in the output register; a later item stalls only at its own hand-off if that
// result is still untaken. Slot states come out of reset empty through per-slot
// valid bits, so no clearing pass is needed.
module linear_probe_hash_table_top #(
    parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lph_pkg::KEY_W-1:0]          s_tdata,   // [31:0] key
    input  logic [lph_pkg::KIND_W-1:0]         s_tuser,   // [1:0] kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lph_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [3:0] slot, [7:4] zero
    output logic [lph_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);

    lph_pkg::dp_cmd_t               cmd;
    lph_pkg::dp_sts_t               sts;
    logic [lph_pkg::SLOT_W-1:0]     slot;

    lph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lph_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_key   (s_tdata),
        .in_kind  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_status (m_tuser),
        .m_slot   (slot)
    );

    assign m_tdata = {{(lph_pkg::OUT_TDATA_W-lph_pkg::SLOT_W){1'b0}}, slot};

endmodule

// ----- hdl/lph_checker.sv -----
// Port-level checks for the linear probe hash table, bound to the top level.
// Depends on lph_pkg and linear_probe_hash_table_top.
module lph_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [lph_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input logic [lph_pkg::STATUS_W-1:0]       m_tuser
);

    // one item at a time: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready stayed high after an accepted item");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != lph_pkg::STATUS_UNUSED))
        else $error("unused status code on output");

    a_slot_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != lph_pkg::STATUS_DONE)) |-> (m_tdata == '0))
        else $error("nonzero slot with a miss or full status");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("output payload changed while stalled");

endmodule

bind linear_probe_hash_table_top lph_checker u_lph_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for linear_probe_hash_table_top.
// Depends on lph_pkg and the RTL under hdl/; predicts every lookup result from its own
// copy of the slot table and checks each result item in order on the master side.
module tb_top;

    localparam int TBL_SLOTS    = lph_pkg::TABLE_SIZE_DEF;
    localparam int POOL_SIZE    = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;

    localparam logic [lph_pkg::KIND_W-1:0] KIND_RSVD = 2'd3;

    typedef struct packed {
        logic [lph_pkg::STATUS_W-1:0] status;
        logic [lph_pkg::SLOT_W-1:0]   slot;
    } lookup_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [lph_pkg::KEY_W-1:0]       s_tdata;
    logic [lph_pkg::KIND_W-1:0]      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [lph_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [lph_pkg::STATUS_W-1:0]    m_tuser;

    logic [1:0]                tbl_state [TBL_SLOTS];
    logic [lph_pkg::KEY_W-1:0] tbl_key   [TBL_SLOTS];
    logic [lph_pkg::KEY_W-1:0] key_pool  [POOL_SIZE];
    lookup_t                   pending_lookups [$];

    int   src_idle;
    int   sink_idle;
    int   mismatches;
    int   stall_cycles;
    int   hold_cnt;
    logic hold_req;
    logic hold_ack = 1'b0;

    linear_probe_hash_table_top #(
        .TABLE_SIZE(TBL_SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 clk = ~clk;

    // Applies one operation to the shadow table and returns the result it should give.
    function automatic lookup_t apply_op(input logic [lph_pkg::KIND_W-1:0] kind,
                                         input logic [lph_pkg::KEY_W-1:0] key);
        lookup_t r;
        int      pos;
        int      hit;
        int      n;
        r.status = lph_pkg::STATUS_NOT_FOUND;
        r.slot   = '0;
        hit      = -1;
        pos      = int'(key % 32'(TBL_SLOTS));
        if (kind == lph_pkg::KIND_INSERT)
        begin
            for (n = 0; n < TBL_SLOTS; n++)
            begin
                if (hit < 0 && tbl_state[pos] == lph_pkg::SLOT_EMPTY)
                    hit = pos;
                pos = (pos + 1) % TBL_SLOTS;
            end
            if (hit < 0)
                r.status = lph_pkg::STATUS_FULL;
            else
            begin
                tbl_state[hit] = lph_pkg::SLOT_USED;
                tbl_key[hit]   = key;
                r.status       = lph_pkg::STATUS_DONE;
                r.slot         = lph_pkg::SLOT_W'(hit);
            end
        end
        else if (kind == lph_pkg::KIND_SEARCH || kind == lph_pkg::KIND_DELETE)
        begin
            for (n = 0; n < TBL_SLOTS; n++)
            begin
                if (hit < 0 && tbl_state[pos] == lph_pkg::SLOT_USED && tbl_key[pos] == key)
                    hit = pos;
                pos = (pos + 1) % TBL_SLOTS;
            end
            if (hit >= 0)
            begin
                if (kind == lph_pkg::KIND_DELETE)
                    tbl_state[hit] = lph_pkg::SLOT_DELETED;
                r.status = lph_pkg::STATUS_DONE;
                r.slot   = lph_pkg::SLOT_W'(hit);
            end
        end
        return r;
    endfunction

    // Offers one item, optionally after a gap; valid stays high for a back-to-back item.
    task automatic send_item(input logic [lph_pkg::KIND_W-1:0] kind,
                             input logic [lph_pkg::KEY_W-1:0] key);
        int gap;
        if ($urandom_range(99) < src_idle)
        begin
            gap = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 70);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= key;
        do @(posedge clk); while (!s_tready);
        pending_lookups.push_back(apply_op(kind, key));
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %0s expected %0d actual %0d", $realtime, what, want, got);
    endtask

    task automatic test_directed();
        int i;
        src_idle  = 34;
        sink_idle = 65;
        send_item(lph_pkg::KIND_INSERT, 32'h0000_0000);
        send_item(lph_pkg::KIND_INSERT, 32'hFFFF_FFFF);
        send_item(lph_pkg::KIND_INSERT, 32'h0000_000F);   // home taken, wraps past slot 0
        send_item(lph_pkg::KIND_INSERT, 32'h0000_0000);   // duplicate key
        send_item(lph_pkg::KIND_SEARCH, 32'h0000_0000);
        send_item(lph_pkg::KIND_DELETE, 32'h0000_0000);
        send_item(lph_pkg::KIND_SEARCH, 32'h0000_0000);   // second copy, skips deleted slot
        send_item(lph_pkg::KIND_SEARCH, 32'h1234_5670);   // absent, full probe
        send_item(lph_pkg::KIND_DELETE, 32'h1234_5670);
        send_item(KIND_RSVD,            32'hFFFF_FFFF);
        send_item(lph_pkg::KIND_INSERT, 32'h8000_0000);   // deleted slot not reused
        send_item(lph_pkg::KIND_DELETE, 32'hFFFF_FFFF);
        send_item(lph_pkg::KIND_SEARCH, 32'h0000_000F);   // probe crosses two deleted slots
        for (i = 0; i < POOL_SIZE - 1; i++)
            send_item(lph_pkg::KIND_INSERT, key_pool[i]);
        send_item(lph_pkg::KIND_INSERT, key_pool[POOL_SIZE-1]);   // no empty slot left
        send_item(lph_pkg::KIND_SEARCH, key_pool[5]);
    endtask

    task automatic test_random(input int count, input int src_pct, input int sink_pct);
        int                         i;
        int                         pick;
        logic [lph_pkg::KEY_W-1:0]  key;
        logic [lph_pkg::KIND_W-1:0] kind;
        src_idle  = src_pct;
        sink_idle = sink_pct;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                key = key_pool[$urandom_range(POOL_SIZE - 1)];
            else if (pick < 72)
                key = $urandom_range(1) ? '1 : '0;
            else
                key = $urandom();
            pick = $urandom_range(99);
            if (pick < 15)
                kind = lph_pkg::KIND_INSERT;
            else if (pick < 18)
                kind = lph_pkg::KIND_DELETE;
            else if (pick < 22)
                kind = KIND_RSVD;
            else
                kind = lph_pkg::KIND_SEARCH;
            send_item(kind, key);
        end
    endtask

    // Receiver stops for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        int i;
        src_idle = 0;
        hold_req <= 1'b1;
        for (i = 0; i < 8; i++)
            send_item(lph_pkg::KIND_SEARCH, key_pool[$urandom_range(POOL_SIZE - 1)]);
    endtask

    always @(posedge clk)
    begin : result_check
        lookup_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch("unexpected item, status", -1, int'(m_tuser));
            else
            begin
                want = pending_lookups.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", int'(want.status), int'(m_tuser));
                if (m_tdata !== lph_pkg::OUT_TDATA_W'(want.slot))
                    report_mismatch("slot", int'(want.slot), int'(m_tdata));
            end
        end
        if (hold_req && !hold_ack)
        begin
            hold_ack <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (rst_n)
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("linear_probe_hash_table_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        int i;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        hold_req   = 1'b0;
        src_idle   = 34;
        sink_idle  = 65;
        mismatches = 0;
        for (i = 0; i < TBL_SLOTS; i++)
            tbl_state[i] = lph_pkg::SLOT_EMPTY;
        // clustered homes around the wrap point to get long probes
        for (i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i][lph_pkg::KEY_W-1:4] = (lph_pkg::KEY_W-4)'($urandom());
            key_pool[i][3:0]                = 4'((14 + $urandom_range(4)) % 16);
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(470, 34, 65);
        test_backpressure();
        test_random(470, 65, 34);
        test_random(470, 0, 0);
        s_tvalid <= 1'b0;

        while (pending_lookups.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("linear_probe_hash_table_top regression: pass");
        else
            $display("linear_probe_hash_table_top regression: fail");
        $finish;
    end

endmodule
